>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers for the checker of this project
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion that is switched off while reset is held
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion that is checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/rvex_pkg.sv
// ----------------------------------------------------------------------------
// rvex_pkg
// opcodes, function codes and fault codes of the rv64i execute block
// ----------------------------------------------------------------------------
package rvex_pkg;

    localparam logic [6:0] OPC_REG    = 7'h33;
    localparam logic [6:0] OPC_IMM    = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;

    localparam logic [2:0] ALU_ADD  = 3'd0;
    localparam logic [2:0] ALU_SLL  = 3'd1;
    localparam logic [2:0] ALU_SLT  = 3'd2;
    localparam logic [2:0] ALU_SLTU = 3'd3;
    localparam logic [2:0] ALU_XOR  = 3'd4;
    localparam logic [2:0] ALU_SR   = 3'd5;
    localparam logic [2:0] ALU_OR   = 3'd6;
    localparam logic [2:0] ALU_AND  = 3'd7;

    localparam logic [2:0] BR_EQ  = 3'd0;
    localparam logic [2:0] BR_NE  = 3'd1;
    localparam logic [2:0] BR_LT  = 3'd4;
    localparam logic [2:0] BR_GE  = 3'd5;
    localparam logic [2:0] BR_LTU = 3'd6;
    localparam logic [2:0] BR_GEU = 3'd7;

    localparam logic [2:0] LD_LB = 3'd0;

    localparam logic [1:0] FC_NONE      = 2'd0;
    localparam logic [1:0] FC_ILLEGAL   = 2'd1;
    localparam logic [1:0] FC_LOAD_MIS  = 2'd2;
    localparam logic [1:0] FC_STORE_MIS = 2'd3;

    localparam logic [3:0] THREAD_COUNT_RESET = 4'd1;

    localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;

endpackage

>>> sv/rvex_if.sv
// ----------------------------------------------------------------------------
// rvex_if
// valid/ready channels for instruction words and result words
// ----------------------------------------------------------------------------
interface rvex_req_if;
    logic        valid;
    logic        ready;
    logic [63:0] pc;
    logic [31:0] instruction;
    logic [3:0]  thread_id;
    logic [63:0] rs1_value;
    logic [63:0] rs2_value;

    modport source (output valid, pc, instruction, thread_id, rs1_value, rs2_value,
                    input ready);
    modport sink   (input valid, pc, instruction, thread_id, rs1_value, rs2_value,
                    output ready);
endinterface

interface rvex_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_out;
    logic        fault;
    logic [1:0]  fault_code;
    logic [63:0] next_pc;
    logic        writes_dest;

    modport source (output valid, value_out, fault, fault_code, next_pc, writes_dest,
                    input ready);
    modport sink   (input valid, value_out, fault, fault_code, next_pc, writes_dest,
                    output ready);
endinterface

>>> sv/rvex_alu.sv
// ----------------------------------------------------------------------------
// rvex_alu
// integer alu for the OP and OP-IMM groups
// ----------------------------------------------------------------------------
module rvex_alu
    import rvex_pkg::*;
(
    input  logic [2:0]  funct3,
    input  logic        alt,
    input  logic        is_reg,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] result
);

    logic [5:0] shamt;

    assign shamt = b[5:0];

    always_comb
    begin
        case (funct3)
            ALU_ADD:  result = (alt && is_reg) ? a - b : a + b;
            ALU_SLL:  result = a << shamt;
            ALU_SLT:  result = {63'd0, $signed(a) < $signed(b)};
            ALU_SLTU: result = {63'd0, a < b};
            ALU_XOR:  result = a ^ b;
            ALU_SR:   result = alt ? 64'($signed(a) >>> shamt) : a >> shamt;
            ALU_OR:   result = a | b;
            ALU_AND:  result = a & b;
            default:  result = a & b;
        endcase
    end

endmodule

>>> sv/rv64i_instruction_execute.sv
// ----------------------------------------------------------------------------
// rv64i_instruction_execute
// rv64i execute unit with a byte-wide data memory
// ----------------------------------------------------------------------------
// req carries one instruction word: pc, instruction, thread id, rs1 and rs2.
// rsp returns one word per instruction: value, fault flag and code, next pc,
// and whether rd is written. thread_count_we/thread_count_wdata set how many
// threads are accepted; write it only while the block is idle.
// a result shows on rsp in the cycle after req is accepted.
// throughput: one instruction per cycle while rsp is not stalled; the data
// memory is read and written in the accept cycle, so a load right after a
// store sees its byte directly. a stalled rsp holds its word; req stays
// ready while the output register is empty or being drained in the same cycle.
// reset: thread_count returns to 1, and a clearing pass zeroes the data
// memory, one byte per cycle, over all MEM_WORDS bytes; req.ready stays low
// during that pass. MEM_WORDS must be a power of two.
// ----------------------------------------------------------------------------
module rv64i_instruction_execute
    import rvex_pkg::*;
#(
    parameter int MEM_WORDS   = 4096,
    parameter int MAX_THREADS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       thread_count_we,
    input  logic [3:0] thread_count_wdata,
    rvex_req_if.sink   req,
    rvex_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(MEM_WORDS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEM_WORDS - 1);
    localparam logic [4:0] MAX_T = 5'(MAX_THREADS);

    // data memory
    logic [7:0]       mem [MEM_WORDS];
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;
    logic             mem_re;
    logic [7:0]       rd_data_reg;

    logic [3:0]       thread_count_reg;
    logic             clearing_reg;
    logic [IDX_W-1:0] clr_idx_reg;

    logic             s_valid_reg;
    logic [63:0]      s_value_reg;
    logic [1:0]       s_code_reg;
    logic [63:0]      s_npc_reg;
    logic             s_wr_reg;
    logic             s_load_reg;
    logic             s_lb_reg;

    logic [63:0]      s_value_next;
    logic [1:0]       s_code_next;
    logic [63:0]      s_npc_next;
    logic             s_wr_next;
    logic             s_load_next;
    logic             s_lb_next;

    logic             accept;
    logic [6:0]       opc;
    logic [2:0]       f3;
    logic             alt;
    logic [63:0]      a;
    logic [63:0]      b;
    logic [63:0]      imm_i;
    logic [63:0]      imm_s;
    logic [63:0]      imm_b;
    logic [63:0]      imm_j;
    logic [63:0]      imm_u;
    logic [63:0]      pc4;
    logic [63:0]      addr;
    logic             misaligned;
    logic [63:0]      tgt_imm;
    logic [63:0]      tgt;
    logic             is_reg;
    logic [63:0]      alu_b;
    logic [63:0]      alu_res;
    logic             taken;
    logic [4:0]       limit;
    logic             bad_thread;

    assign accept = req.valid && req.ready;
    assign req.ready = !clearing_reg && (!s_valid_reg || rsp.ready);

    // decode
    assign opc   = req.instruction[6:0];
    assign f3    = req.instruction[14:12];
    assign alt   = req.instruction[30];
    assign a     = (req.instruction[19:15] != 5'd0) ? req.rs1_value : 64'd0;
    assign b     = (req.instruction[24:20] != 5'd0) ? req.rs2_value : 64'd0;
    assign imm_i = {{52{req.instruction[31]}}, req.instruction[31:20]};
    assign imm_s = {{52{req.instruction[31]}}, req.instruction[31:25],
                    req.instruction[11:7]};
    assign imm_b = {{51{req.instruction[31]}}, req.instruction[31], req.instruction[7],
                    req.instruction[30:25], req.instruction[11:8], 1'b0};
    assign imm_j = {{43{req.instruction[31]}}, req.instruction[31],
                    req.instruction[19:12], req.instruction[20],
                    req.instruction[30:21], 1'b0};
    assign imm_u = {{32{req.instruction[31]}}, req.instruction & UPPER_MASK};

    assign pc4        = req.pc + 64'd4;
    assign addr       = a + ((opc == OPC_STORE) ? imm_s : imm_i);
    assign misaligned = addr[2:0] != 3'd0;

    always_comb
    begin
        case (opc)
            OPC_BRANCH: tgt_imm = imm_b;
            OPC_JAL:    tgt_imm = imm_j;
            default:    tgt_imm = imm_u;
        endcase
    end
    assign tgt = req.pc + tgt_imm;

    assign is_reg = opc == OPC_REG;
    assign alu_b  = is_reg ? b : imm_i;

    rvex_alu u_alu (
        .funct3 (f3),
        .alt    (alt),
        .is_reg (is_reg),
        .a      (a),
        .b      (alu_b),
        .result (alu_res)
    );

    always_comb
    begin
        case (f3)
            BR_EQ:   taken = a == b;
            BR_NE:   taken = a != b;
            BR_LT:   taken = $signed(a) < $signed(b);
            BR_GE:   taken = !($signed(a) < $signed(b));
            BR_LTU:  taken = a < b;
            BR_GEU:  taken = a >= b;
            default: taken = 1'b0;
        endcase
    end

    // thread_count above the build limit acts as the limit
    assign limit      = ({1'b0, thread_count_reg} > MAX_T) ? MAX_T
                                                           : {1'b0, thread_count_reg};
    assign bad_thread = {1'b0, req.thread_id} >= limit;

    always_comb
    begin
        s_value_next = 64'd0;
        s_code_next  = FC_NONE;
        s_npc_next   = pc4;
        s_wr_next    = 1'b1;
        s_load_next  = 1'b0;
        s_lb_next    = f3 == LD_LB;
        case (opc)
            OPC_REG, OPC_IMM:
            begin
                s_value_next = alu_res;
            end
            OPC_LOAD:
            begin
                if (misaligned)
                    s_code_next = FC_LOAD_MIS;
                else
                    s_load_next = 1'b1;
            end
            OPC_STORE:
            begin
                s_wr_next = 1'b0;
                if (misaligned)
                    s_code_next = FC_STORE_MIS;
            end
            OPC_BRANCH:
            begin
                s_wr_next = 1'b0;
                if (taken)
                    s_npc_next = tgt;
            end
            OPC_JAL:
            begin
                s_value_next = pc4;
                s_npc_next   = tgt;
            end
            OPC_JALR:
            begin
                s_value_next = pc4;
                s_npc_next   = {addr[63:1], 1'b0};
            end
            OPC_LUI:
            begin
                s_value_next = imm_u;
            end
            OPC_AUIPC:
            begin
                s_value_next = tgt;
            end
            default:
            begin
                s_code_next = FC_ILLEGAL;
            end
        endcase
        if (bad_thread)
        begin
            s_value_next = 64'd0;
            s_code_next  = FC_ILLEGAL;
            s_npc_next   = 64'd0;
            s_wr_next    = 1'b0;
            s_load_next  = 1'b0;
        end
    end

    // memory ports: clearing pass or aligned store on the write side
    assign mem_re    = accept && (opc == OPC_LOAD);
    assign mem_we    = clearing_reg ||
                       (accept && !bad_thread && (opc == OPC_STORE) && !misaligned);
    assign mem_waddr = clearing_reg ? clr_idx_reg : addr[3 +: IDX_W];
    assign mem_wdata = clearing_reg ? 8'd0 : b[7:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            rd_data_reg <= mem[addr[3 +: IDX_W]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thread_count_reg <= THREAD_COUNT_RESET;
            clearing_reg     <= 1'b1;
            clr_idx_reg      <= '0;
            s_valid_reg      <= 1'b0;
        end
        else
        begin
            if (thread_count_we)
                thread_count_reg <= thread_count_wdata;
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX)
                    clearing_reg <= 1'b0;
            end
            if (accept)
                s_valid_reg <= 1'b1;
            else if (rsp.ready)
                s_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_value_reg <= s_value_next;
            s_code_reg  <= s_code_next;
            s_npc_reg   <= s_npc_next;
            s_wr_reg    <= s_wr_next;
            s_load_reg  <= s_load_next;
            s_lb_reg    <= s_lb_next;
        end
    end

    // output word, load byte extended here
    assign rsp.valid       = s_valid_reg;
    assign rsp.value_out   = s_load_reg ? {{56{s_lb_reg & rd_data_reg[7]}}, rd_data_reg}
                                        : s_value_reg;
    assign rsp.fault       = s_code_reg != FC_NONE;
    assign rsp.fault_code  = s_code_reg;
    assign rsp.next_pc     = s_npc_reg;
    assign rsp.writes_dest = s_wr_reg;

endmodule

>>> sv/rvex_checker.sv
// ----------------------------------------------------------------------------
// rvex_checker
// port-level checks of the rv64i execute block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rvex_checker
    import rvex_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       rsp_fault,
    input logic [1:0] rsp_fault_code,
    input logic       rsp_writes_dest
);

    `ASSERT_RST(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid, "rsp word dropped while stalled")

    `ASSERT_RST(a_accept_gives_rsp, clk, rst_n, req_valid && req_ready |=> rsp_valid, "accepted word gave no result")

    // every result word comes from an accept or is a held word
    `ASSERT_RST(a_rsp_source, clk, rst_n, rsp_valid |-> $past(req_valid && req_ready) || $past(rsp_valid && !rsp_ready), "result word without a source")

    `ASSERT_ALWAYS(a_store_fault, clk, rsp_valid && rsp_fault_code == FC_STORE_MIS |-> rsp_fault && !rsp_writes_dest, "store fault writes rd")

endmodule

bind rv64i_instruction_execute rvex_checker u_rvex_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_fault       (rsp.fault),
    .rsp_fault_code  (rsp.fault_code),
    .rsp_writes_dest (rsp.writes_dest)
);

>>> bench/tb_rv64i_instruction_execute.sv
// ----------------------------------------------------------------------------
// tb_rv64i_instruction_execute
// self-checking bench: directed rows, then random instruction words, each
// result word compared against a row's given result or an in-bench rv64i execute model
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rv64i_instruction_execute;
    import rvex_pkg::*;

    localparam int MEM_WORDS    = 4096;
    localparam int MAX_THREADS  = 8;
    localparam int IDX_W        = $clog2(MEM_WORDS);
    localparam int CLK_HALF     = 6;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int PHASE_N      = 8;

    localparam logic [6:0]  OPC_UNKNOWN = 7'h3F;
    localparam logic [6:0]  F7_BASE     = 7'h00;
    localparam logic [6:0]  F7_ALT      = 7'h20;
    localparam logic [6:0]  F7_JUNK     = 7'h7F;
    localparam logic [2:0]  BR_RSVD     = 3'd2;
    localparam logic [2:0]  LD_D        = 3'd3;
    localparam logic [2:0]  ST_D        = 3'd3;
    localparam logic [63:0] BASE_PC     = 64'h0000_0000_0000_1000;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SIGN_BIT    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_POS     = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] pc;
        logic [31:0] instruction;
        logic [3:0]  thread_id;
        logic [63:0] rs1_value;
        logic [63:0] rs2_value;
    } instr_word_t;

    typedef struct packed {
        logic [63:0] value_out;
        logic        fault;
        logic [1:0]  fault_code;
        logic [63:0] next_pc;
        logic        writes_dest;
    } result_word_t;

    typedef struct {
        instr_word_t  word;
        bit           typed;
        result_word_t result;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       thread_count_we;
    logic [3:0] thread_count_wdata;

    rvex_req_if req_ch ();
    rvex_rsp_if rsp_ch ();

    rv64i_instruction_execute #(
        .MEM_WORDS   (MEM_WORDS),
        .MAX_THREADS (MAX_THREADS)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .thread_count_we    (thread_count_we),
        .thread_count_wdata (thread_count_wdata),
        .req                (req_ch),
        .rsp                (rsp_ch)
    );

    always #(CLK_HALF) clk = ~clk;

    // model state
    logic [7:0]   data_mem [MEM_WORDS];
    logic [3:0]   threads_cfg;
    result_word_t retire_q [$];
    dir_row_t     directed_rows [$];
    int           mismatch_cnt = 0;
    int           cycles = 0;
    bit           no_idle = 1'b0;

    int  phase_threads [PHASE_N] = '{8, 0, 15, 3, 8, 1, 11, 6};
    int  phase_items   [PHASE_N] = '{400, 40, 300, 250, 300, 150, 250, 260};
    bit  phase_calm    [PHASE_N] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

    // ------------------------------------------------------------------------
    // instruction encoders, rd is always x10
    // ------------------------------------------------------------------------
    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [6:0] op);
        return {f7, rs2, rs1, f3, 5'd10, op};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [6:0] op);
        return {imm, rs1, f3, 5'd10, op};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    function automatic logic [31:0] enc_u(logic [19:0] imm, logic [6:0] op);
        return {imm, 5'd10, op};
    endfunction

    function automatic logic [31:0] enc_j(logic [20:0] imm);
        return {imm[20], imm[10:1], imm[11], imm[19:12], 5'd10, OPC_JAL};
    endfunction

    function automatic dir_row_t stim_row(logic [63:0] pc, logic [31:0] ins, logic [3:0] tid,
                                          logic [63:0] a, logic [63:0] b);
        dir_row_t d;
        d.word   = '{pc, ins, tid, a, b};
        d.typed  = 1'b0;
        d.result = '0;
        return d;
    endfunction

    function automatic dir_row_t with_result(dir_row_t d, logic [63:0] v, logic f,
                                             logic [1:0] c, logic [63:0] npc, logic wr);
        d.typed  = 1'b1;
        d.result = '{v, f, c, npc, wr};
        return d;
    endfunction

    // ------------------------------------------------------------------------
    // execute model
    // ------------------------------------------------------------------------
    function automatic logic [63:0] alu_result(logic [2:0] f3, logic alt, logic is_reg,
                                               logic [63:0] a, logic [63:0] b);
        logic [5:0]  sh;
        logic [63:0] r;
        sh = b[5:0];
        case (f3)
            ALU_ADD:  r = (alt && is_reg) ? a - b : a + b;
            ALU_SLL:  r = a << sh;
            ALU_SLT:  r = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
            ALU_SLTU: r = (a < b) ? 64'd1 : 64'd0;
            ALU_XOR:  r = a ^ b;
            ALU_SR:
            begin
                if (alt)
                    r = $signed(a) >>> sh;
                else
                    r = a >> sh;
            end
            ALU_OR:   r = a | b;
            default:  r = a & b;
        endcase
        return r;
    endfunction

    function automatic result_word_t execute_instr(instr_word_t w);
        result_word_t r;
        logic [31:0]  ins;
        logic [2:0]   f3;
        logic [63:0]  a;
        logic [63:0]  b;
        logic [63:0]  immi;
        logic [63:0]  imm;
        logic [63:0]  addr;
        logic [63:0]  upper;
        logic         taken;
        logic [1:0]   code;
        int           lim;
        ins   = w.instruction;
        f3    = ins[14:12];
        a     = (ins[19:15] != 5'd0) ? w.rs1_value : 64'd0;
        b     = (ins[24:20] != 5'd0) ? w.rs2_value : 64'd0;
        immi  = {{52{ins[31]}}, ins[31:20]};
        upper = {{32{ins[31]}}, ins[31:12], 12'd0};
        lim   = (threads_cfg > MAX_THREADS) ? MAX_THREADS : int'(threads_cfg);
        code  = FC_NONE;
        taken = 1'b0;
        r     = '{64'd0, 1'b0, FC_NONE, w.pc + 64'd4, 1'b1};
        if (int'(w.thread_id) >= lim)
            return '{64'd0, 1'b1, FC_ILLEGAL, 64'd0, 1'b0};
        case (ins[6:0])
            OPC_REG:   r.value_out = alu_result(f3, ins[30], 1'b1, a, b);
            OPC_IMM:   r.value_out = alu_result(f3, ins[30], 1'b0, a, immi);
            OPC_LOAD:
            begin
                addr = a + immi;
                if (addr[2:0] != 3'd0)
                    code = FC_LOAD_MIS;
                else if (f3 == LD_LB)
                    r.value_out = {{56{data_mem[addr[3 +: IDX_W]][7]}},
                                   data_mem[addr[3 +: IDX_W]]};
                else
                    r.value_out = {56'd0, data_mem[addr[3 +: IDX_W]]};
            end
            OPC_STORE:
            begin
                imm  = {{52{ins[31]}}, ins[31:25], ins[11:7]};
                addr = a + imm;
                r.writes_dest = 1'b0;
                if (addr[2:0] != 3'd0)
                    code = FC_STORE_MIS;
                else
                    data_mem[addr[3 +: IDX_W]] = b[7:0];
            end
            OPC_BRANCH:
            begin
                imm = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
                case (f3)
                    BR_EQ:   taken = (a == b);
                    BR_NE:   taken = (a != b);
                    BR_LT:   taken = ($signed(a) < $signed(b));
                    BR_GE:   taken = !($signed(a) < $signed(b));
                    BR_LTU:  taken = (a < b);
                    BR_GEU:  taken = (a >= b);
                    default: taken = 1'b0;
                endcase
                if (taken)
                    r.next_pc = w.pc + imm;
                r.writes_dest = 1'b0;
            end
            OPC_JAL:
            begin
                imm = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
                r.value_out = w.pc + 64'd4;
                r.next_pc   = w.pc + imm;
            end
            OPC_JALR:
            begin
                r.value_out = w.pc + 64'd4;
                r.next_pc   = (a + immi) & ~64'd1;
            end
            OPC_LUI:   r.value_out = upper;
            OPC_AUIPC: r.value_out = w.pc + upper;
            default:   code = FC_ILLEGAL;
        endcase
        r.fault      = (code != FC_NONE);
        r.fault_code = code;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // random stimulus
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [63:0] rand_operand();
        case ($urandom_range(0, 9))
            0:       return 64'd0;
            1:       return ALL_ONES;
            2:       return SIGN_BIT;
            3:       return MAX_POS;
            4:       return 64'($urandom_range(0, 70));
            5:       return -64'($urandom_range(1, 70));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic instr_word_t make_word();
        instr_word_t w;
        logic [31:0] ins;
        logic [63:0] imm;
        logic [63:0] target;
        int          sel;
        int          lim;
        ins = $urandom;
        sel = $urandom_range(0, 99);
        lim = (threads_cfg > MAX_THREADS) ? MAX_THREADS : int'(threads_cfg);
        if ($urandom_range(0, 4) == 0)
            w.pc = ALL_ONES - 64'($urandom_range(0, 63));
        else
            w.pc = {$urandom, $urandom};
        if (lim > 0 && $urandom_range(0, 9) > 0)
            w.thread_id = 4'($urandom_range(0, lim - 1));
        else
            w.thread_id = 4'($urandom);
        if ($urandom_range(0, 9) == 0)
            ins[19:15] = 5'd0;
        if ($urandom_range(0, 9) == 0)
            ins[24:20] = 5'd0;
        w.rs1_value = rand_operand();
        w.rs2_value = ($urandom_range(0, 4) == 0) ? w.rs1_value : rand_operand();
        if (sel < 14)
            ins[6:0] = OPC_REG;
        else if (sel < 28)
            ins[6:0] = OPC_IMM;
        else if (sel < 60)
        begin
            if (sel < 44)
            begin
                ins[6:0]   = OPC_LOAD;
                ins[22:20] = 3'd0;
                imm        = {{52{ins[31]}}, ins[31:20]};
            end
            else
            begin
                ins[6:0] = OPC_STORE;
                ins[9:7] = 3'd0;
                imm      = {{52{ins[31]}}, ins[31:25], ins[11:7]};
            end
            // most accesses aligned and packed onto a few bytes so loads hit stores
            if ($urandom_range(0, 6) > 0)
            begin
                target = ($urandom_range(0, 3) == 0) ? ({$urandom, $urandom} & ~64'h7FFF)
                                                     : 64'd0;
                if ($urandom_range(0, 3) > 0)
                    target[3 +: IDX_W] = IDX_W'($urandom_range(0, 15));
                else
                    target[3 +: IDX_W] = IDX_W'($urandom_range(0, MEM_WORDS - 1));
                w.rs1_value = target - imm;
            end
        end
        else if (sel < 72)
            ins[6:0] = OPC_BRANCH;
        else if (sel < 77)
            ins[6:0] = OPC_JAL;
        else if (sel < 83)
            ins[6:0] = OPC_JALR;
        else if (sel < 88)
            ins[6:0] = OPC_LUI;
        else if (sel < 93)
            ins[6:0] = OPC_AUIPC;
        else
        begin
            ins[6:0] = 7'($urandom);
            while (ins[6:0] == OPC_REG || ins[6:0] == OPC_IMM || ins[6:0] == OPC_LOAD ||
                   ins[6:0] == OPC_STORE || ins[6:0] == OPC_BRANCH || ins[6:0] == OPC_JAL ||
                   ins[6:0] == OPC_JALR || ins[6:0] == OPC_LUI || ins[6:0] == OPC_AUIPC)
                ins[6:0] = 7'($urandom);
        end
        w.instruction = ins;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    task automatic drive_word(input instr_word_t w, input bit typed,
                              input result_word_t known);
        int           gap;
        result_word_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.pc          <= w.pc;
        req_ch.instruction <= w.instruction;
        req_ch.thread_id   <= w.thread_id;
        req_ch.rs1_value   <= w.rs1_value;
        req_ch.rs2_value   <= w.rs2_value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // the model runs even for typed rows so the data memory stays in step
        predicted = execute_instr(w);
        retire_q.push_back(typed ? known : predicted);
    endtask

    task automatic set_threads(input logic [3:0] v);
        req_ch.valid <= 1'b0;
        while (retire_q.size() != 0)
            @(posedge clk);
        thread_count_we    <= 1'b1;
        thread_count_wdata <= v;
        @(posedge clk);
        thread_count_we <= 1'b0;
        threads_cfg = v;
    endtask

    task automatic note_mismatch(input string what, input result_word_t e,
                                 input result_word_t g);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t: %s: exp value=%h fault=%b code=%0d next_pc=%h wr=%b, got value=%h fault=%b code=%0d next_pc=%h wr=%b",
                     $realtime, what, e.value_out, e.fault, e.fault_code, e.next_pc,
                     e.writes_dest, g.value_out, g.fault, g.fault_code, g.next_pc,
                     g.writes_dest);
    endtask

    // ------------------------------------------------------------------------
    // response side: random stalls and checking
    // ------------------------------------------------------------------------
    initial
    begin
        int           stall_left;
        int           burst_left;
        result_word_t got;
        result_word_t want;
        stall_left = 0;
        burst_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                got = '{rsp_ch.value_out, rsp_ch.fault, rsp_ch.fault_code, rsp_ch.next_pc,
                        rsp_ch.writes_dest};
                if (retire_q.size() == 0)
                    note_mismatch("word with nothing pending", '0, got);
                else
                begin
                    want = retire_q.pop_front();
                    if (got !== want)
                        note_mismatch("word mismatch", want, got);
                end
            end
            if (stall_left == 0 && burst_left == 0)
            begin
                stall_left = pick_gap();
                burst_left = $urandom_range(1, 16);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                burst_left--;
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        thread_count_we    <= 1'b0;
        thread_count_wdata <= 4'd0;
        req_ch.valid       <= 1'b0;
        req_ch.pc          <= 64'd0;
        req_ch.instruction <= 32'd0;
        req_ch.thread_id   <= 4'd0;
        req_ch.rs1_value   <= 64'd0;
        req_ch.rs2_value   <= 64'd0;
        foreach (data_mem[i])
            data_mem[i] = 8'd0;
        threads_cfg = THREAD_COUNT_RESET;

        // thread limit is still at its reset value of one here
        directed_rows.push_back(with_result(stim_row(BASE_PC,
            enc_r(F7_BASE, 5'd2, 5'd1, ALU_ADD, OPC_REG), 4'd1, 64'd5, 64'd6),
            64'd0, 1'b1, FC_ILLEGAL, 64'd0, 1'b0));
        // bad thread store must leave memory alone
        directed_rows.push_back(with_result(stim_row(BASE_PC,
            enc_s(12'd0, 5'd2, 5'd0, ST_D), 4'd15, 64'd0, 64'hAB),
            64'd0, 1'b1, FC_ILLEGAL, 64'd0, 1'b0));
        directed_rows.push_back(with_result(stim_row(ALL_ONES - 64'd3,
            {25'h1FF_FFFF, OPC_UNKNOWN}, 4'd0, ALL_ONES, ALL_ONES),
            64'd0, 1'b1, FC_ILLEGAL, 64'd0, 1'b1));
        directed_rows.push_back(with_result(stim_row(BASE_PC,
            enc_i(12'd0, 5'd0, LD_LB, OPC_LOAD), 4'd0, 64'hFFFF, 64'd0),
            64'd0, 1'b0, FC_NONE, BASE_PC + 64'd4, 1'b1));
        directed_rows.push_back(with_result(stim_row(BASE_PC,
            enc_i(12'd3, 5'd1, LD_LB, OPC_LOAD), 4'd0, 64'd0, 64'd0),
            64'd0, 1'b1, FC_LOAD_MIS, BASE_PC + 64'd4, 1'b1));
        directed_rows.push_back(with_result(stim_row(BASE_PC,
            enc_s(12'd0, 5'd2, 5'd1, ST_D), 4'd0, 64'd9, 64'h55),
            64'd0, 1'b1, FC_STORE_MIS, BASE_PC + 64'd4, 1'b0));
        // address wraps past the top to 8
        directed_rows.push_back(stim_row(BASE_PC, enc_s(12'd16, 5'd2, 5'd1, ST_D), 4'd0,
            ALL_ONES - 64'd7, 64'h1234_5678_9ABC_DEFF));
        directed_rows.push_back(with_result(stim_row(BASE_PC,
            enc_i(12'd8, 5'd0, LD_LB, OPC_LOAD), 4'd0, 64'd0, 64'd0),
            ALL_ONES, 1'b0, FC_NONE, BASE_PC + 64'd4, 1'b1));
        // high address bits alias onto the same byte
        directed_rows.push_back(stim_row(BASE_PC, enc_i(12'd0, 5'd1, LD_D, OPC_LOAD), 4'd0,
            64'h8000_0000_0000_8008, 64'd0));
        directed_rows.push_back(with_result(stim_row(BASE_PC,
            enc_r(F7_BASE, 5'd2, 5'd1, ALU_ADD, OPC_REG), 4'd0, ALL_ONES, 64'd1),
            64'd0, 1'b0, FC_NONE, BASE_PC + 64'd4, 1'b1));
        directed_rows.push_back(with_result(stim_row(BASE_PC,
            enc_r(F7_ALT, 5'd2, 5'd1, ALU_ADD, OPC_REG), 4'd0, 64'd0, 64'd1),
            ALL_ONES, 1'b0, FC_NONE, BASE_PC + 64'd4, 1'b1));
        // immediate with bit 30 set still adds
        directed_rows.push_back(stim_row(BASE_PC, enc_i(12'h400, 5'd1, ALU_ADD, OPC_IMM),
            4'd0, 64'd1, 64'd0));
        directed_rows.push_back(stim_row(BASE_PC, enc_r(F7_BASE, 5'd2, 5'd1, ALU_SLL, OPC_REG),
            4'd0, 64'd1, ALL_ONES));
        directed_rows.push_back(stim_row(BASE_PC, enc_r(F7_BASE, 5'd2, 5'd1, ALU_SLT, OPC_REG),
            4'd0, SIGN_BIT, MAX_POS));
        directed_rows.push_back(stim_row(BASE_PC,
            enc_r(F7_BASE, 5'd2, 5'd1, ALU_SLTU, OPC_REG), 4'd0, SIGN_BIT, MAX_POS));
        directed_rows.push_back(stim_row(BASE_PC, enc_i(12'hFFF, 5'd1, ALU_XOR, OPC_IMM),
            4'd0, 64'h0123_4567_89AB_CDEF, 64'd0));
        directed_rows.push_back(stim_row(BASE_PC, enc_r(F7_ALT, 5'd2, 5'd1, ALU_SR, OPC_REG),
            4'd0, SIGN_BIT, 64'd63));
        directed_rows.push_back(stim_row(BASE_PC, enc_i(12'h03F, 5'd1, ALU_SR, OPC_IMM),
            4'd0, ALL_ONES, 64'd0));
        // funct7 bits other than bit 30 are don't-care
        directed_rows.push_back(stim_row(BASE_PC, enc_r(F7_JUNK, 5'd2, 5'd1, ALU_OR, OPC_REG),
            4'd0, 64'hF0F0_F0F0_F0F0_F0F0, 64'h0F0F_0F0F_0F0F_0F0F));
        directed_rows.push_back(stim_row(BASE_PC, enc_i(12'hFF0, 5'd1, ALU_AND, OPC_IMM),
            4'd0, ALL_ONES, 64'd0));
        directed_rows.push_back(stim_row(BASE_PC, enc_b(13'h1FF8, 5'd2, 5'd1, BR_EQ), 4'd0,
            64'd5, 64'd5));
        directed_rows.push_back(stim_row(BASE_PC, enc_b(13'h0FFE, 5'd2, 5'd1, BR_LT), 4'd0,
            SIGN_BIT, 64'd0));
        // rs2 is x0, so its value reads as zero
        directed_rows.push_back(stim_row(BASE_PC, enc_b(13'd64, 5'd0, 5'd1, BR_GEU), 4'd0,
            64'd0, 64'd1));
        directed_rows.push_back(stim_row(BASE_PC, enc_b(13'd16, 5'd2, 5'd1, BR_RSVD), 4'd0,
            64'd7, 64'd7));
        directed_rows.push_back(stim_row(BASE_PC, enc_j(21'h1F_FFFC), 4'd0, 64'd0, 64'd0));
        directed_rows.push_back(stim_row(BASE_PC, enc_i(12'd1, 5'd1, ALU_ADD, OPC_JALR),
            4'd0, 64'h1234, 64'd0));
        directed_rows.push_back(with_result(stim_row(BASE_PC, enc_u(20'h80000, OPC_LUI),
            4'd0, 64'd0, 64'd0),
            64'hFFFF_FFFF_8000_0000, 1'b0, FC_NONE, BASE_PC + 64'd4, 1'b1));
        directed_rows.push_back(stim_row(64'h800, enc_u(20'hFFFFF, OPC_AUIPC), 4'd0,
            64'd0, 64'd0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            drive_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);

        for (int p = 0; p < PHASE_N; p++)
        begin
            set_threads(4'(phase_threads[p]));
            no_idle = phase_calm[p];
            repeat (phase_items[p])
                drive_word(make_word(), 1'b0, '0);
        end

        req_ch.valid <= 1'b0;
        while (retire_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
